FILE: sv/tdf_pkg.sv
// Shared constants and types of the trial division factorizer.
`timescale 1ns / 1ps
`default_nettype none
package tdf_pkg;

  // Bits of the input number that take part in factoring.
  localparam int unsigned NUM_BITS = 16;
  localparam int unsigned VAL_W    = NUM_BITS;
  // Room for the divisor squared, which may step just past the value range.
  localparam int unsigned SQ_W     = NUM_BITS + 2;
  // Bit counter of the serial divider, counting NUM_BITS-1 down to 0.
  localparam int unsigned CNT_W    = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

  // Width of the external number and factor ports.
  localparam int unsigned PORT_W   = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAD,
    S_CHECK,
    S_DIV,
    S_EMIT,
    S_TAIL
  } tdf_state_e;

endpackage
`default_nettype wire

FILE: sv/tdf_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tdf_div
  import tdf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [VAL_W-1:0] dividend_i,
  input  wire logic [VAL_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [VAL_W-1:0]      quot_o,
  output logic                  rem_zero_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic [VAL_W-1:0] part_q, part_d;
  logic [VAL_W-1:0] dvs_q, dvs_d;

  logic [VAL_W:0]   trial;
  logic [VAL_W:0]   diff;
  logic             qbit;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  assign trial = {part_q, acc_q[VAL_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign qbit  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    part_d = part_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_BITS - 1);
      acc_d  = dividend_i;
      part_d = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      part_d = qbit ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      acc_d  = {acc_q[VAL_W-2:0], qbit};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    part_q <= part_d;
    dvs_q  <= dvs_d;
  end

  assign done_o     = done_q;
  assign quot_o     = acc_q;
  assign rem_zero_o = (part_q == '0);

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished pass");

  a_last_bit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && (cnt_q == '0) |=> done_q)
    else $error("divider did not finish after its last bit");
`endif

endmodule
`default_nettype wire

FILE: sv/trial_division_factorizer_top.sv
// Top level of the trial division factorizer.
`timescale 1ns / 1ps
`default_nettype none
// Takes one unsigned number per input word and returns its prime factorization as a run of
// output words: first the value 1, then each prime factor in ascending order, repeated as often
// as it divides the number, with last_o set on the final word of the run. An input of 1 gives
// the single word 1 (marked last); an input of 0 gives no output at all. Divisors are tried in
// ascending order from 2 while the divisor squared does not exceed what remains; a remainder
// above 1 at that point is itself prime and closes the run. Each trial goes through a
// bit-serial restoring divider that resolves one quotient bit per cycle. The worst case is a
// prime near 2^16, which tries about 255 divisors; small or smooth numbers finish far sooner.
// One number is worked on at a time: in_ready_o is high only while the sequencer is idle, but
// the final word of a run sits in an output register, so the next number is taken while that
// word still waits for out_ready_i.
module trial_division_factorizer_top
  import tdf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [PORT_W-1:0] num_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [PORT_W-1:0]      factor_o,
  output logic                   last_o
);

  tdf_state_e       state_q, state_d;
  logic [VAL_W-1:0] rem_q, rem_d;    // part of the number not yet factored
  logic [VAL_W-1:0] dv_q, dv_d;      // divisor under trial
  logic [SQ_W-1:0]  sq_q, sq_d;      // dv_q squared, kept by running sums
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] factor_q, factor_d;
  logic             last_q, last_d;

  logic             in_fire;
  logic             slot_free;
  logic [VAL_W-1:0] num_n;
  logic             sq_fits;
  logic             div_start;
  logic             div_done;
  logic [VAL_W-1:0] div_quot;
  logic             div_rem_zero;

  // Only the low NUM_BITS bits of the number take part.
  assign num_n     = VAL_W'(num_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire   = in_valid_i && in_ready_o;
  // The output register can take a new word when empty or being drained now.
  assign slot_free = !out_valid_q || out_ready_i;
  assign sq_fits   = (sq_q <= SQ_W'(rem_q));
  assign div_start = (state_q == S_CHECK) && sq_fits;

  tdf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_q),
    .divisor_i  (dv_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_zero_o (div_rem_zero)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (num_n != '0)) state_d = S_LEAD;
      end
      S_LEAD: begin
        if (slot_free) state_d = (rem_q == VAL_W'(1)) ? S_IDLE : S_CHECK;
      end
      S_CHECK: begin
        if (sq_fits)                     state_d = S_DIV;
        else if (rem_q > VAL_W'(1))      state_d = S_TAIL;
        else                             state_d = S_IDLE;
      end
      S_DIV: begin
        if (div_done) state_d = div_rem_zero ? S_EMIT : S_CHECK;
      end
      S_EMIT: begin
        if (slot_free) state_d = S_CHECK;
      end
      S_TAIL: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    rem_d       = rem_q;
    dv_d        = dv_q;
    sq_d        = sq_q;
    factor_d    = factor_q;
    last_d      = last_q;
    // Drop the held word once taken.
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          rem_d = num_n;
          dv_d  = VAL_W'(2);
          sq_d  = SQ_W'(4);
        end
      end
      S_LEAD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          factor_d    = VAL_W'(1);
          last_d      = (rem_q == VAL_W'(1));
        end
      end
      S_CHECK: ;
      S_DIV: begin
        if (div_done) begin
          if (div_rem_zero) begin
            // Divisor divides: keep it, the quotient is what remains.
            rem_d = div_quot;
          end else begin
            // Advance the divisor; (d+1)^2 = d^2 + 2d + 1.
            dv_d = dv_q + VAL_W'(1);
            sq_d = sq_q + SQ_W'({dv_q, 1'b1});
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          factor_d    = dv_q;
          last_d      = (rem_q == VAL_W'(1));
        end
      end
      S_TAIL: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          factor_d    = rem_q;
          last_d      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      dv_q        <= VAL_W'(2);
      sq_q        <= SQ_W'(4);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      dv_q        <= dv_d;
      sq_q        <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    factor_q <= factor_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign factor_o    = PORT_W'(factor_q);
  assign last_o      = last_q;

`ifndef ASSERT_OFF
  a_busy_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (rem_q != '0))
    else $error("remaining value is zero during a run");

  a_divisor_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (dv_q >= VAL_W'(2)))
    else $error("trial divisor below two");

  a_hit_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && div_done && div_rem_zero |=> (state_q == S_EMIT))
    else $error("exact division not followed by a factor word");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside a trial");
`endif

endmodule
`default_nettype wire

FILE: sim/factor_run_checker.sv
// Checker for the trial division factorizer: predicts each factor run and compares it.
`timescale 1ns / 1ps
module factor_run_checker
  import tdf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire logic [PORT_W-1:0] num_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire logic [PORT_W-1:0] factor_i,
  input  wire logic              last_i,
  output int                     mismatches_o,
  output int                     pending_words_o,
  output int                     numbers_seen_o,
  output int                     words_seen_o
);

  typedef struct packed {
    logic [PORT_W-1:0] factor;
    logic              last;
  } factor_word_t;

  // Ring of predicted words, oldest at exp_head.
  localparam int EXP_DEPTH = 64;

  factor_word_t expected_words[EXP_DEPTH];
  int exp_head     = 0;
  int exp_tail     = 0;
  int exp_count    = 0;
  int mismatches   = 0;
  int numbers_seen = 0;
  int words_seen   = 0;

  initial begin
    mismatches_o    = 0;
    pending_words_o = 0;
    numbers_seen_o  = 0;
    words_seen_o    = 0;
  end

  function automatic void add_word(input int unsigned factor, input bit last);
    factor_word_t w;
    w.factor = factor[PORT_W-1:0];
    w.last   = last;
    if (exp_count >= EXP_DEPTH) begin
      mismatches++;
      $error("prediction store overflow");
    end else begin
      expected_words[exp_tail] = w;
      exp_tail  = (exp_tail + 1) % EXP_DEPTH;
      exp_count++;
    end
  endfunction

  function automatic factor_word_t take_word();
    factor_word_t w;
    w         = expected_words[exp_head];
    exp_head  = (exp_head + 1) % EXP_DEPTH;
    exp_count--;
    return w;
  endfunction

  // Ascending trial division: leading 1, then every prime factor with repetition.
  function automatic void predict_factors(input logic [PORT_W-1:0] num);
    int unsigned rest;
    int unsigned divisor;
    rest = int'(num) & ((32'd1 << NUM_BITS) - 1);
    if (rest == 0) return;
    add_word(1, rest == 1);
    divisor = 2;
    while (divisor * divisor <= rest) begin
      if (rest % divisor == 0) begin
        rest = rest / divisor;
        add_word(divisor, rest == 1);
      end else begin
        divisor++;
      end
    end
    if (rest > 1) add_word(rest, 1'b1);
  endfunction

  always @(posedge clk_i) begin
    factor_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        predict_factors(num_i);
        numbers_seen++;
      end
      if (out_valid_i && out_ready_i) begin
        words_seen++;
        if (exp_count == 0) begin
          mismatches++;
          $error("unexpected word: factor %0d last %0b", factor_i, last_i);
        end else begin
          want = take_word();
          if (factor_i !== want.factor) begin
            mismatches++;
            $error("factor: expected %0d, got %0d", want.factor, factor_i);
          end
          if (last_i !== want.last) begin
            mismatches++;
            $error("last: expected %0b, got %0b", want.last, last_i);
          end
        end
      end
    end
    mismatches_o    <= mismatches;
    pending_words_o <= exp_count;
    numbers_seen_o  <= numbers_seen;
    words_seen_o    <= words_seen;
  end

endmodule

FILE: sim/testbench.sv
// Testbench top: drives numbers into the factorizer, stalls the output, reports the verdict.
`timescale 1ns / 1ps
module testbench;
  import tdf_pkg::*;

  // Slowest legal run: a prime near 2^16, plus up to 16 words each held by an
  // output stall, and an input gap. The limit allows several times what about
  // 140 such numbers would need.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_ITEMS = 117;
  // Idle cycles granted after the last word, in case a zero is still draining.
  localparam int SETTLE       = 64;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [PORT_W-1:0] num_i       = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [PORT_W-1:0] factor_o;
  logic              last_o;

  int mismatches;
  int pending_words;
  int numbers_seen;
  int words_seen;

  // Set for stretches with no idling on either side; driven at the rising edge.
  logic calm       = 1'b0;
  int   stall_left = 0;
  int   cycle_count;

  trial_division_factorizer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .num_i       (num_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .factor_o    (factor_o),
    .last_o      (last_o)
  );

  factor_run_checker factor_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .num_i           (num_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .factor_i        (factor_o),
    .last_i          (last_o),
    .mismatches_o    (mismatches),
    .pending_words_o (pending_words),
    .numbers_seen_o  (numbers_seen),
    .words_seen_o    (words_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stall the result side in random bursts; hold ready high when calm.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (calm) begin
      stall_left = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Small primes for smooth numbers, mid primes near the square-root boundary,
  // and the largest primes of the range, which take the longest to factor.
  function automatic int unsigned prime_at(input int unsigned idx);
    case (idx)
      0:       return 2;
      1:       return 3;
      2:       return 5;
      3:       return 7;
      4:       return 11;
      5:       return 13;
      6:       return 101;
      7:       return 127;
      8:       return 239;
      9:       return 251;
      10:      return 257;
      11:      return 8191;
      12:      return 16381;
      13:      return 32749;
      14:      return 65519;
      default: return 65521;
    endcase
  endfunction

  // Draw a number: mostly uniform and small values, plus smooth products with
  // long runs of repeated factors, large primes and products of two mid primes.
  function automatic logic [PORT_W-1:0] pick_number();
    int unsigned value;
    int unsigned p;
    int unsigned q;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: value = $urandom_range(0, 65535);
      4, 5:       value = $urandom_range(0, 300);
      6, 7: begin
        value = 1;
        repeat ($urandom_range(1, 16)) begin
          p = prime_at($urandom_range(0, 5));
          if (value * p <= 65535) value = value * p;
        end
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          value = prime_at($urandom_range(11, 15));
        end else begin
          p = prime_at($urandom_range(6, 10));
          q = prime_at($urandom_range(6, 10));
          value = (p * q <= 65535) ? p * q : p;
        end
      end
    endcase
    return value[PORT_W-1:0];
  endfunction

  // Offer one word, after an optional gap, and hold it until accepted.
  task automatic send_number(input logic [PORT_W-1:0] value);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    num_i      <= value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every predicted word has come back. The checker
  // updates its counts at the rising edge, so read them at the falling edge.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_words != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Give up if the run overstays the limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, one, small primes and composites, powers of two (the
    // longest run), the largest primes, prime squares and alternating bits.
    send_number(16'd0);     send_number(16'd1);     send_number(16'd2);
    send_number(16'd3);     send_number(16'd4);     send_number(16'd6);
    send_number(16'd12);    send_number(16'd49);    send_number(16'd1024);
    send_number(16'd32768); send_number(16'd30030); send_number(16'd65534);
    send_number(16'd65535); send_number(16'd65521); send_number(16'd65519);
    send_number(16'd63001); send_number(16'd65025); send_number(16'd32749);
    send_number(16'd8191);  send_number(16'hAAAA);  send_number(16'h5555);
    send_number(16'd0);     send_number(16'd1);

    // Let the pipeline run dry once before the random part.
    drain_results();

    // Random: a calm stretch in the middle and another near the end.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      calm <= (k >= 40 && k < 60) || (k >= RANDOM_ITEMS - 25);
      send_number(pick_number());
      if (k == 70) drain_results();
    end

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);

    $display("Covered %0d numbers: zero, one, primes up to 65521, prime squares,",
             numbers_seen);
    $display("powers of two and random values, with %0d factor words checked under stalls.",
             words_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
